>>> hw/rtl/lsf_pkg.sv
// Package for the line substring filter.
// Widths, register indexes and the control struct passed to the window cells.
// No dependencies.
package lsf_pkg;

    localparam int LSF_PATTERN_MAX = 32;   // window depth default
    localparam int LSF_REG_CHARS   = 32;   // bytes held by the pattern registers
    localparam int LSF_CHAR_W      = 8;
    localparam int LSF_LEN_W       = 6;
    localparam int LSF_CFG_W       = 64;
    localparam int LSF_CFG_IDX_W   = 3;
    localparam int LSF_PAT_W       = LSF_REG_CHARS * LSF_CHAR_W;

    typedef enum logic [LSF_CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_CHARS_A = 3'd1,
        REG_PATTERN_CHARS_B = 3'd2,
        REG_PATTERN_CHARS_C = 3'd3,
        REG_PATTERN_CHARS_D = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic shift;   // text byte transfer: move the window along
        logic clear;   // newline transfer: empty the window
    } t_cell_ctrl;

endpackage

>>> hw/rtl/lsf_in_if.sv
// Input channel of the line substring filter: text byte and newline flag.
// Depends on lsf_pkg.
interface lsf_in_if import lsf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LSF_CHAR_W-1:0] text_char;
    logic                  is_newline;

    modport source (output valid, output text_char, output is_newline, input ready);
    modport sink   (input valid, input text_char, input is_newline, output ready);
endinterface

>>> hw/rtl/lsf_out_if.sv
// Result channel of the line substring filter: one match flag per line.
// No dependencies.
interface lsf_out_if ();
    logic valid;
    logic ready;
    logic line_matches;

    modport source (output valid, output line_matches, input ready);
    modport sink   (input valid, input line_matches, output ready);
endinterface

>>> hw/rtl/lsf_cell.sv
// One window cell: holds one recent byte and whether it belongs to the line.
// Depends on lsf_pkg.
module lsf_cell import lsf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [LSF_CHAR_W-1:0] i_char,     // from the newer neighbour
    input  logic                  i_valid,
    input  logic [LSF_CHAR_W-1:0] i_expect,   // pattern byte aligned to this cell
    input  logic                  i_in_use,   // cell lies inside the pattern length
    output logic [LSF_CHAR_W-1:0] o_char,
    output logic                  o_valid,
    output logic                  o_ok        // this cell agrees after the shift
);

    logic [LSF_CHAR_W-1:0] r_char;
    logic                  r_valid;

    // ok is judged on the window as it stands after this shift
    assign o_ok    = !i_in_use || (i_valid && (i_char == i_expect));
    assign o_char  = r_char;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_char <= i_char;
        end
    end

endmodule

>>> hw/rtl/line_substring_filter.sv
// Top level of the line substring filter: config registers, cell row, result register.
// Depends on lsf_pkg, lsf_in_if, lsf_out_if and lsf_cell.
//
//  channel    dir  payload                     per transfer
//  i_text     in   text_char[7:0], is_newline  one byte or one line end
//  o_result   out  line_matches                one flag per line end
//  cfg port   in   i_cfg_we/index[2:0]/data    one register write
//
// One item per cycle unless i_text.ready is low: the window compare across the row
// of cells is parallel and a byte's match is folded into the found flag in the cycle
// it arrives. A line end loads its result into the output register in the next cycle.
// i_text.ready drops only while a result is held and o_result.ready is low.
// Reset (synchronous, active low) empties the window and clears the config,
// the found flag and the result valid.
module line_substring_filter import lsf_pkg::*; #(
    parameter int PATTERN_MAX = LSF_PATTERN_MAX
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [LSF_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LSF_CFG_W-1:0]     i_cfg_data,
    lsf_in_if.sink                   i_text,
    lsf_out_if.source                o_result
);

    logic [LSF_LEN_W-1:0] r_len;
    logic [LSF_PAT_W-1:0] r_pattern;
    logic                 r_found;
    logic                 r_out_valid;
    logic                 r_out_match;
    logic                 n_found;

    logic                  w_in_xfer;
    logic                  w_len_ok;
    t_cell_ctrl            w_ctrl;
    logic [LSF_CHAR_W-1:0] w_char [PATTERN_MAX];
    logic                  w_vld  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_ok;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pattern <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PATTERN_LENGTH:  r_len <= i_cfg_data[LSF_LEN_W-1:0];
                REG_PATTERN_CHARS_A: r_pattern[0*LSF_CFG_W +: LSF_CFG_W] <= i_cfg_data;
                REG_PATTERN_CHARS_B: r_pattern[1*LSF_CFG_W +: LSF_CFG_W] <= i_cfg_data;
                REG_PATTERN_CHARS_C: r_pattern[2*LSF_CFG_W +: LSF_CFG_W] <= i_cfg_data;
                REG_PATTERN_CHARS_D: r_pattern[3*LSF_CFG_W +: LSF_CFG_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_text.ready = !r_out_valid || o_result.ready;
    assign w_in_xfer    = i_text.valid && i_text.ready;
    assign w_ctrl.shift = w_in_xfer && !i_text.is_newline;
    assign w_ctrl.clear = w_in_xfer && i_text.is_newline;

    assign w_len_ok = (r_len != '0)
                   && ({1'b0, r_len} <= (LSF_LEN_W+1)'(PATTERN_MAX))
                   && ({1'b0, r_len} <= (LSF_LEN_W+1)'(LSF_REG_CHARS));

    assign w_char[0] = i_text.text_char;
    assign w_vld[0]  = 1'b1;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            localparam logic [LSF_LEN_W-1:0] CELL_IDX = LSF_LEN_W'(k);
            logic [LSF_LEN_W-1:0]  w_j;
            logic [LSF_CHAR_W-1:0] w_expect;
            logic [LSF_CHAR_W-1:0] w_next_char;
            logic                  w_next_vld;

            // cell k sees pattern byte len-1-k
            assign w_j      = r_len - LSF_LEN_W'(1) - CELL_IDX;
            assign w_expect = r_pattern[{w_j[4:0], 3'b000} +: LSF_CHAR_W];

            lsf_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (w_ctrl),
                .i_char   (w_char[k]),
                .i_valid  (w_vld[k]),
                .i_expect (w_expect),
                .i_in_use (CELL_IDX < r_len),
                .o_char   (w_next_char),
                .o_valid  (w_next_vld),
                .o_ok     (w_ok[k])
            );

            if (k < PATTERN_MAX - 1) begin : g_link
                assign w_char[k+1] = w_next_char;
                assign w_vld[k+1]  = w_next_vld;
            end
        end
    endgenerate

    always_comb begin
        n_found = r_found;
        if (w_ctrl.clear) begin
            n_found = 1'b0;
        end else if (w_ctrl.shift && w_len_ok && (&w_ok)) begin
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_found <= n_found;
            if (w_ctrl.clear) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.clear) begin
            r_out_match <= r_found || (r_len == '0);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.line_matches = r_out_match;

`ifndef SYNTH
    a_nl_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear |=> r_out_valid)
        else $error("line end did not load a result");

    a_nl_clears_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear |=> !r_found)
        else $error("found flag survived a line end");

    a_byte_fills_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.shift |=> g_cell[0].w_next_vld)
        else $error("newest cell not marked after a byte transfer");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_text.ready |-> r_out_valid)
        else $error("input stalled with no result held");
`endif

endmodule
